/* rtl/rsb_pkg.sv */
// Shared types and constants for the clipped RLE sprite blitter.
`timescale 1ns / 1ps
package rsb_pkg;

	localparam int COORD_BITS = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] SKIP_FLAG = 8'h80;
	localparam logic [31:0] PREFIX_WORD = 32'h0000_0002;

	localparam logic [12:0] DEST_WIDTH_RST = 13'd320;
	localparam logic [12:0] DEST_HEIGHT_RST = 13'd200;

	typedef enum logic [1:0] {
		REG_DEST_WIDTH = 2'd0,
		REG_DEST_HEIGHT = 2'd1,
		REG_ORIGIN_X = 2'd2,
		REG_ORIGIN_Y = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FS_HDR0,
		FS_HDR1,
		FS_HDR2,
		FS_HDR3,
		FS_BODY,
		FS_DONE
	} front_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [7:0]            pixel_color;
		logic                  write_enable;
		logic                  last;
	} out_item_t;

	// Work handed from the decoder to the clipping stage.
	typedef struct packed {
		logic        is_pix;
		logic        last;
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0]  color;
	} rsb_item_t;

	typedef struct packed {
		logic [12:0] dest_width;
		logic [12:0] dest_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
	} rsb_cfg_t;

endpackage

/* rtl/rsb_front.sv */
// Stream decoder: header parsing, run tracking and source position.
`timescale 1ns / 1ps
module rsb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  rsb_pkg::in_item_t  item,
	output logic               push,
	output rsb_pkg::rsb_item_t push_item
);

	rsb_pkg::front_state_t state_q, state_d;
	logic [23:0] hdr_q, hdr_d;
	logic        prefix_q, prefix_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [7:0]  lit_q, lit_d;

	rsb_pkg::front_state_t cur;
	logic        cur_prefix;
	logic [7:0]  db;
	logic [31:0] hdr_word;
	logic [16:0] col_inc;
	logic [16:0] col_skip;
	logic [15:0] row_inc;
	logic [7:0]  skip_len;
	logic        is_skip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsb_pkg::FS_DONE;
			prefix_q <= 1'b0;
			lit_q <= '0;
		end else begin
			state_q <= state_d;
			prefix_q <= prefix_d;
			lit_q <= lit_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q <= hdr_d;
		width_q <= width_d;
		height_q <= height_d;
		col_q <= col_d;
		row_q <= row_d;
	end

	assign db = item.data_byte;
	assign hdr_word = {db, hdr_q};
	assign col_inc = {1'b0, col_q} + 17'd1;
	assign skip_len = db - rsb_pkg::SKIP_FLAG;
	assign col_skip = {1'b0, col_q} + {10'd0, skip_len[6:0]};
	assign row_inc = (row_q != 16'hFFFF) ? row_q + 16'd1 : row_q;
	assign is_skip = db[7] && ({8'd0, skip_len} <= width_q);

	always_comb begin
		state_d = state_q;
		hdr_d = hdr_q;
		prefix_d = prefix_q;
		width_d = width_q;
		height_d = height_q;
		col_d = col_q;
		row_d = row_q;
		lit_d = lit_q;
		push = 1'b0;
		push_item = '0;
		push_item.col = col_q;
		push_item.row = row_q;
		push_item.color = (db != 8'd0) ? db : 8'd1;

		// A first byte restarts parsing whatever the current state.
		cur = item.first_byte ? rsb_pkg::FS_HDR0 : state_q;
		cur_prefix = item.first_byte ? 1'b0 : prefix_q;

		if (take) begin
			if (item.first_byte) begin
				prefix_d = 1'b0;
				lit_d = '0;
			end
			case (cur)
				rsb_pkg::FS_HDR0: begin
					hdr_d[7:0] = db;
					state_d = rsb_pkg::FS_HDR1;
				end
				rsb_pkg::FS_HDR1: begin
					hdr_d[15:8] = db;
					state_d = rsb_pkg::FS_HDR2;
				end
				rsb_pkg::FS_HDR2: begin
					hdr_d[23:16] = db;
					state_d = rsb_pkg::FS_HDR3;
				end
				rsb_pkg::FS_HDR3: begin
					if (!cur_prefix && hdr_word == rsb_pkg::PREFIX_WORD) begin
						// drop the prefix and parse the real header
						prefix_d = 1'b1;
						state_d = rsb_pkg::FS_HDR0;
					end else begin
						width_d = hdr_word[15:0];
						height_d = hdr_word[31:16];
						col_d = '0;
						row_d = '0;
						lit_d = '0;
						if (hdr_word[15:0] == 16'd0 || hdr_word[31:16] == 16'd0) begin
							state_d = rsb_pkg::FS_DONE;
							push = 1'b1;
							push_item.last = 1'b1;
						end else begin
							state_d = rsb_pkg::FS_BODY;
						end
					end
				end
				rsb_pkg::FS_BODY: begin
					if (lit_q != 8'd0) begin
						push = 1'b1;
						push_item.is_pix = 1'b1;
						lit_d = lit_q - 8'd1;
						if (col_inc >= {1'b0, width_q}) begin
							col_d = '0;
							row_d = row_inc;
						end else begin
							col_d = col_inc[15:0];
						end
					end else if (is_skip) begin
						// skip past the row end wraps into the next row once
						if (col_skip >= {1'b0, width_q}) begin
							col_d = 16'(col_skip - {1'b0, width_q});
							row_d = row_inc;
						end else begin
							col_d = col_skip[15:0];
						end
					end else begin
						lit_d = db;
					end
					if (lit_d == 8'd0 && row_d >= height_q) begin
						state_d = rsb_pkg::FS_DONE;
						push = 1'b1;
						push_item.last = 1'b1;
					end
				end
				rsb_pkg::FS_DONE: begin
					state_d = rsb_pkg::FS_DONE;
				end
				default: begin
					state_d = rsb_pkg::FS_DONE;
				end
			endcase
		end
	end

endmodule

/* rtl/rsb_queue.sv */
// Short queue between the decoder and the clipping stage.
`timescale 1ns / 1ps
module rsb_queue #(
	parameter int DEPTH = rsb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsb_pkg::rsb_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output rsb_pkg::rsb_item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsb_pkg::rsb_item_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = slots_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/rsb_back.sv */
// Clipping stage: places pixels on the destination and holds the result register.
`timescale 1ns / 1ps
module rsb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsb_pkg::rsb_cfg_t   cfg,
	input  logic                head_valid,
	input  rsb_pkg::rsb_item_t  head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output rsb_pkg::out_item_t  out_data
);

	logic signed [17:0] x_s;
	logic signed [17:0] y_s;
	logic [16:0] x_u;
	logic [16:0] y_u;
	logic x_ok;
	logic y_ok;
	logic we;
	logic load;
	logic valid_q;
	rsb_pkg::out_item_t data_q;

	assign x_s = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {2'b00, head_item.col};
	assign y_s = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {2'b00, head_item.row};
	assign x_u = x_s[16:0];
	assign y_u = y_s[16:0];
	assign x_ok = !x_s[17] && (x_u < {4'd0, cfg.dest_width})
		&& (x_u[16:rsb_pkg::COORD_BITS] == '0);
	assign y_ok = !y_s[17] && (y_u < {4'd0, cfg.dest_height})
		&& (y_u[16:rsb_pkg::COORD_BITS] == '0);
	assign we = head_item.is_pix && x_ok && y_ok;

	// advance whenever the result register is free or being taken
	assign load = !valid_q || !out_stall;
	assign pop = load && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid && (we || head_item.last);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.pixel_x <= we ? x_u[rsb_pkg::COORD_BITS-1:0] : '0;
			data_q.pixel_y <= we ? y_u[rsb_pkg::COORD_BITS-1:0] : '0;
			data_q.pixel_color <= we ? head_item.color : 8'd0;
			data_q.write_enable <= we;
			data_q.last <= head_item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

/* rtl/rle_sprite_blit_clipped_core.sv */
// Clipped RLE sprite blitter top level: configuration registers and stage wiring.
//
// Input channel (in_valid/in_stall/in_data) takes one sprite stream byte per
// transfer; first_byte restarts header parsing. Bytes that arrive while no
// sprite is open are dropped. Output channel (out_valid/out_stall/out_data)
// carries one result per pixel write that lands on the destination, and one
// marked last for the byte that completes the image.
// Configuration: cfg_write with cfg_index selects dest_width, dest_height,
// origin_x, origin_y; write only while no byte is in flight.
// Throughput: one byte per cycle while in_stall is low; the decoder handles
// each byte combinationally, and the clipping stage drains the queue at one
// entry per cycle while the receiver does not stall. A result is written to
// a queue slot as its byte transfers, then to the result register (out_data).
// When the receiver stalls, the result register holds and the queue
// (QUEUE_DEPTH entries) fills; in_stall rises once it is full.
// Reset clears the queue, the result register and the decoder, which then
// waits for a first byte; configuration returns to 320 x 200 at origin 0,0.
`timescale 1ns / 1ps
module rle_sprite_blit_clipped_core #(
	parameter int QUEUE_DEPTH = rsb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rsb_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rsb_pkg::out_item_t out_data,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	rsb_pkg::rsb_cfg_t cfg_q;
	logic take;
	logic push;
	logic full;
	logic pop;
	logic head_valid;
	rsb_pkg::rsb_item_t push_item;
	rsb_pkg::rsb_item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_width <= rsb_pkg::DEST_WIDTH_RST;
			cfg_q.dest_height <= rsb_pkg::DEST_HEIGHT_RST;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
		end else if (cfg_write) begin
			case (rsb_pkg::cfg_reg_t'(cfg_index))
				rsb_pkg::REG_DEST_WIDTH: cfg_q.dest_width <= cfg_data[12:0];
				rsb_pkg::REG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data[12:0];
				rsb_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				rsb_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = full;
	assign take = in_valid && !full;

	rsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (in_data),
		.push      (push),
		.push_item (push_item)
	);

	rsb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rsb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

/* rtl/rsb_checker.sv */
// Port-level checks for the clipped RLE sprite blitter, bound to the top level.
`timescale 1ns / 1ps
module rsb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input rsb_pkg::out_item_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_enable |-> out_data.last)
		else $error("result carries neither a write nor last");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_enable |->
		out_data.pixel_x == '0 && out_data.pixel_y == '0 && out_data.pixel_color == 8'd0)
		else $error("non-write result has nonzero fields");

	a_color_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_enable |-> out_data.pixel_color != 8'd0)
		else $error("pixel write with color zero");

endmodule

bind rle_sprite_blit_clipped_core rsb_checker u_rsb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* verif/rsb_scoreboard_pkg.sv */
// Pixel scoreboard for the clipped RLE sprite blitter: decoder mirror and result checks.
`timescale 1ns / 1ps
package rsb_scoreboard_pkg;

	import rsb_pkg::*;

	class pixel_scoreboard;
		// register mirror
		logic [12:0] view_w;
		logic [12:0] view_h;
		logic [15:0] org_x;
		logic [15:0] org_y;
		// decoder mirror
		int unsigned hdr_cnt;
		logic [31:0] hdr_word;
		bit          prefix_dropped;
		bit          closed;
		int unsigned spr_w;
		int unsigned spr_h;
		int unsigned col;
		int unsigned row;
		int unsigned run_left;

		out_item_t   writes_due[$];
		int          errors;
		int          accepted;
		int          writes;
		int          image_ends;

		function new();
			view_w = DEST_WIDTH_RST;
			view_h = DEST_HEIGHT_RST;
			org_x = '0;
			org_y = '0;
			hdr_cnt = 0;
			hdr_word = '0;
			prefix_dropped = 0;
			closed = 1;
			spr_w = 0;
			spr_h = 0;
			col = 0;
			row = 0;
			run_left = 0;
			errors = 0;
			accepted = 0;
			writes = 0;
			image_ends = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] v);
			case (idx)
			REG_DEST_WIDTH: view_w = v[12:0];
			REG_DEST_HEIGHT: view_h = v[12:0];
			REG_ORIGIN_X: org_x = v;
			default: org_y = v;
			endcase
		endfunction

		function void bump_row();
			if (row < 32'hFFFF)
				row++;
		endfunction

		function int outstanding();
			return writes_due.size();
		endfunction

		// Advance the decoder by one transferred byte and queue the result it causes.
		function void decode_byte(in_item_t it);
			logic [7:0] b;
			bit         wr;
			bit         done;
			int         sx;
			int         sy;
			out_item_t  r;
			b = it.data_byte;
			wr = 0;
			done = 0;
			r = '0;
			if (it.first_byte) begin
				closed = 0;
				hdr_cnt = 0;
				hdr_word = '0;
				prefix_dropped = 0;
				run_left = 0;
			end else if (closed) begin
				return;
			end
			accepted++;
			if (hdr_cnt < 4) begin
				hdr_word |= 32'(b) << (8 * hdr_cnt);
				hdr_cnt++;
				if (hdr_cnt < 4)
					return;
				// drop the prefix word once; a repeat is a real header
				if (!prefix_dropped && hdr_word == PREFIX_WORD) begin
					prefix_dropped = 1;
					hdr_cnt = 0;
					hdr_word = '0;
					return;
				end
				spr_w = hdr_word[15:0];
				spr_h = hdr_word[31:16];
				col = 0;
				row = 0;
				run_left = 0;
				if (spr_w == 0 || spr_h == 0) begin
					closed = 1;
					done = 1;
				end
			end else begin
				if (run_left > 0) begin
					sx = int'($signed(org_x)) + int'(col);
					sy = int'($signed(org_y)) + int'(row);
					if (sx >= 0 && sy >= 0 && sx < int'(view_w) && sy < int'(view_h) &&
							sx < (1 << COORD_BITS) && sy < (1 << COORD_BITS)) begin
						wr = 1;
						r.pixel_x = sx[COORD_BITS-1:0];
						r.pixel_y = sy[COORD_BITS-1:0];
						r.pixel_color = (b == 8'd0) ? 8'd1 : b;
					end
					run_left--;
					col++;
					if (col >= spr_w) begin
						col = 0;
						bump_row();
					end
				end else if (b[7] && b[6:0] <= spr_w) begin
					// skip wraps at most once into the next row
					col += b[6:0];
					if (col >= spr_w) begin
						col -= spr_w;
						bump_row();
					end
				end else begin
					run_left = b;
				end
				if (run_left == 0 && row >= spr_h) begin
					closed = 1;
					done = 1;
				end
			end
			if (wr || done) begin
				r.write_enable = wr;
				r.last = done;
				writes_due.insert(writes_due.size(), r);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] pixel check: %s", $realtime, msg);
		endtask

		task compare_pixel(out_item_t got);
			out_item_t want;
			if (writes_due.size() == 0) begin
				report($sformatf("result x=%0d y=%0d c=%0d we=%b last=%b with nothing due",
					got.pixel_x, got.pixel_y, got.pixel_color, got.write_enable, got.last));
				return;
			end
			want = writes_due.pop_front();
			if (got.pixel_x !== want.pixel_x)
				report($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
			if (got.pixel_y !== want.pixel_y)
				report($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
			if (got.pixel_color !== want.pixel_color)
				report($sformatf("pixel_color %0d, want %0d", got.pixel_color, want.pixel_color));
			if (got.write_enable !== want.write_enable)
				report($sformatf("write_enable %b, want %b", got.write_enable, want.write_enable));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
			if (want.write_enable)
				writes++;
			if (want.last)
				image_ends++;
		endtask
	endclass

endpackage

/* verif/tb.sv */
// Testbench top for the clipped RLE sprite blitter: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps
module tb;

	import rsb_pkg::*;
	import rsb_scoreboard_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_write;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	pixel_scoreboard sb = new();
	int burst_left = 0;
	int sprites_sent = 0;
	int view_count = 0;

	rle_sprite_blit_clipped_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: switch between open, light, heavy and long-run stall patterns.
	initial begin
		int mode;
		int span;
		mode = 0;
		span = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(40, 300);
			end
			span--;
			case (mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= (span % 16) < 11;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write)
				sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && in_stall === 1'b0)
				sb.decode_byte(in_data);
			if (out_valid === 1'b1 && !out_stall)
				sb.compare_pixel(out_data);
		end
	end

	// Present one byte and hold it until the transfer; gaps fall between bursts.
	task automatic put_byte(input logic [7:0] b, input bit fb);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 15) == 0)
				gap = $urandom_range(10, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, first_byte: fb};
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	// Hold the sender until every due result has drained, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic set_view(input int w, input int h, input int ox, input int oy);
		cfg_write <= 1'b1;
		cfg_index <= REG_DEST_WIDTH;
		cfg_data <= 16'(w);
		@(posedge clk);
		cfg_index <= REG_DEST_HEIGHT;
		cfg_data <= 16'(h);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= 16'(ox);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_data <= 16'(oy);
		@(posedge clk);
		cfg_write <= 1'b0;
		view_count++;
	endtask

	task automatic put_pixels(input int n, inout int spent, input int budget);
		for (int i = 0; i < n; i++) begin
			if (spent >= budget)
				return;
			put_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)), 0);
			spent++;
		end
	endtask

	// Header plus a well-formed body; budget caps the body bytes to truncate it.
	task automatic send_sprite(input int w, input int h, input bit pre, input int budget);
		longint pos;
		longint total;
		int     k;
		int     n;
		int     spent;
		bit     fb;
		fb = 1;
		if (pre) begin
			put_byte(8'h02, 1);
			put_byte(8'h00, 0);
			put_byte(8'h00, 0);
			put_byte(8'h00, 0);
			fb = 0;
		end
		put_byte(w[7:0], fb);
		put_byte(w[15:8], 0);
		put_byte(h[7:0], 0);
		put_byte(h[15:8], 0);
		sprites_sent++;
		total = longint'(w) * longint'(h);
		pos = 0;
		spent = 0;
		while (pos < total && spent < budget) begin
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: begin
				k = $urandom_range(0, (w < 127) ? w : 127);
				put_byte(8'h80 + 8'(k), 0);
				spent++;
				pos += k;
			end
			6: begin
				put_byte(8'h00, 0);
				spent++;
			end
			7: begin
				// code with bit 7 set but too wide to be a skip: long literal run
				if (w < 120) begin
					n = $urandom_range(129 + w, 135 + w);
					put_byte(8'(n), 0);
					spent++;
					pos += n;
					put_pixels(n, spent, budget);
				end
			end
			default: begin
				n = $urandom_range(1, 8);
				put_byte(8'(n), 0);
				spent++;
				pos += n;
				put_pixels(n, spent, budget);
			end
			endcase
		end
	endtask

	task automatic random_sprite();
		int sel;
		int n;
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			n = $urandom_range(1, 12);
			repeat (n) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end else if (sel < 10) begin
			send_sprite($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 1), $urandom_range(1, 24));
		end else if (sel < 14) begin
			if ($urandom_range(0, 1))
				send_sprite(0, $urandom_range(0, 65535), $urandom_range(0, 1), 0);
			else
				send_sprite($urandom_range(1, 65535), 0, $urandom_range(0, 1), 0);
		end else begin
			send_sprite($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(0, 4) == 0,
				(sel < 24) ? $urandom_range(2, 30) : 100000);
		end
	endtask

	task automatic run_phase(input int w, input int h, input int ox, input int oy, input int n);
		int target;
		wait_idle();
		set_view(w, h, ox, oy);
		target = sb.accepted + n;
		while (sb.accepted < target) random_sprite();
	endtask

	initial begin
		int dw;
		int dh;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_write <= 1'b0;
		cfg_index <= REG_DEST_WIDTH;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no sprite open yet: dropped
		put_byte(8'hFF, 0);
		put_byte(8'h00, 0);
		// prefixed 1x1 sprite, colour 0 turns into 1 and closes the image
		put_byte(8'h02, 1);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);
		put_byte(8'h01, 0);
		put_byte(8'h00, 0);
		put_byte(8'h01, 0);
		put_byte(8'h00, 0);
		put_byte(8'h01, 0);
		put_byte(8'h00, 0);
		// 5x2: skip, skip that wraps, empty skip, empty run, one pixel
		put_byte(8'h05, 1);
		put_byte(8'h00, 0);
		put_byte(8'h02, 0);
		put_byte(8'h00, 0);
		put_byte(8'h82, 0);
		put_byte(8'h84, 0);
		put_byte(8'h80, 0);
		put_byte(8'h00, 0);
		put_byte(8'h01, 0);
		put_byte(8'hFF, 0);
		// restart mid-sprite; the second prefix word is a real 2x0 header
		put_byte(8'h02, 1);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);
		put_byte(8'h02, 0);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);
		put_byte(8'h00, 0);

		run_phase(4096, 4096, 0, 0, 60);
		run_phase(1, 1, 0, 0, 60);
		run_phase(8, 6, -3, -2, 60);
		run_phase(4096, 4096, 4090, 4093, 60);
		run_phase(8191, 8191, 4091, 4093, 60);
		run_phase(320, 200, -32768, 32767, 40);
		run_phase(0, 0, -1, -1, 30);
		repeat (7) begin
			dw = $urandom_range(1, 24);
			dh = $urandom_range(1, 16);
			run_phase(dw, dh, int'($urandom_range(0, dw + 8)) - 8,
				int'($urandom_range(0, dh + 8)) - 8, 60);
		end
		wait_idle();

		$display("ran %0d stream bytes in %0d sprites across %0d destination views",
			sb.accepted, sprites_sent, view_count);
		$display("checked %0d pixel writes and %0d image completions, %0d errors",
			sb.writes, sb.image_ends, sb.errors);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("timed out with %0d results still due", sb.outstanding());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
